// ----- sv/gmo_pkg.sv -----
// Shared types, widths and the tangent threshold table for the gradient
// magnitude and orientation block. Depends on nothing else.
package gmo_pkg;

    localparam int ANGLE_FRACTION_BITS = 16;

    localparam int GRAD_W      = 11;
    localparam int BYTE_W      = 8;
    localparam int SUM_W       = 2 * GRAD_W;
    localparam int ROOT_W      = 8;
    localparam int SQ_W        = 2 * ROOT_W;
    localparam int IDX_W       = 5;
    localparam int TAN_ENTRIES = 1 << IDX_W;
    localparam int TAN_W       = ANGLE_FRACTION_BITS + 1;
    localparam int PROD_W      = GRAD_W + TAN_W;
    localparam int QUAD_W      = 2;
    localparam int STEP_W      = 6;
    localparam int CELL_COUNT  = ROOT_W;
    localparam int ANGLE_CELLS = IDX_W;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [GRAD_W-1:0] grad_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [ROOT_W-1:0] root_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [TAN_W-1:0]  tan_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [QUAD_W-1:0] quad_t;
    typedef logic [STEP_W-1:0] step_t;

    // One item as it travels down the chain of cells.
    typedef struct packed {
        byte_t horiz_display;
        byte_t vert_display;
        sum_t  sq_sum;
        root_t root;
        grad_t near_side;
        grad_t far_side;
        logic  shallow;
        quad_t quadrant;
        logic  zero_vec;
        idx_t  step_idx;
    } gmo_item_t;

    // Q31 recurrence for tan(k*pi/128), evaluated at elaboration.
    localparam logic [63:0] TAN_STEP_Q31 = 64'd52717765;
    localparam logic [63:0] Q31_ONE      = 64'h0000_0000_8000_0000;
    localparam logic [63:0] Q31_HALF     = 64'h0000_0000_4000_0000;

    localparam logic [63:0] TQ00 = 64'd0;
    localparam logic [63:0] DN00 = Q31_ONE - ((TQ00 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ01 = (((TQ00 + TAN_STEP_Q31) << 31) + DN00 / 2) / DN00;
    localparam logic [63:0] DN01 = Q31_ONE - ((TQ01 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ02 = (((TQ01 + TAN_STEP_Q31) << 31) + DN01 / 2) / DN01;
    localparam logic [63:0] DN02 = Q31_ONE - ((TQ02 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ03 = (((TQ02 + TAN_STEP_Q31) << 31) + DN02 / 2) / DN02;
    localparam logic [63:0] DN03 = Q31_ONE - ((TQ03 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ04 = (((TQ03 + TAN_STEP_Q31) << 31) + DN03 / 2) / DN03;
    localparam logic [63:0] DN04 = Q31_ONE - ((TQ04 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ05 = (((TQ04 + TAN_STEP_Q31) << 31) + DN04 / 2) / DN04;
    localparam logic [63:0] DN05 = Q31_ONE - ((TQ05 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ06 = (((TQ05 + TAN_STEP_Q31) << 31) + DN05 / 2) / DN05;
    localparam logic [63:0] DN06 = Q31_ONE - ((TQ06 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ07 = (((TQ06 + TAN_STEP_Q31) << 31) + DN06 / 2) / DN06;
    localparam logic [63:0] DN07 = Q31_ONE - ((TQ07 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ08 = (((TQ07 + TAN_STEP_Q31) << 31) + DN07 / 2) / DN07;
    localparam logic [63:0] DN08 = Q31_ONE - ((TQ08 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ09 = (((TQ08 + TAN_STEP_Q31) << 31) + DN08 / 2) / DN08;
    localparam logic [63:0] DN09 = Q31_ONE - ((TQ09 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ10 = (((TQ09 + TAN_STEP_Q31) << 31) + DN09 / 2) / DN09;
    localparam logic [63:0] DN10 = Q31_ONE - ((TQ10 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ11 = (((TQ10 + TAN_STEP_Q31) << 31) + DN10 / 2) / DN10;
    localparam logic [63:0] DN11 = Q31_ONE - ((TQ11 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ12 = (((TQ11 + TAN_STEP_Q31) << 31) + DN11 / 2) / DN11;
    localparam logic [63:0] DN12 = Q31_ONE - ((TQ12 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ13 = (((TQ12 + TAN_STEP_Q31) << 31) + DN12 / 2) / DN12;
    localparam logic [63:0] DN13 = Q31_ONE - ((TQ13 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ14 = (((TQ13 + TAN_STEP_Q31) << 31) + DN13 / 2) / DN13;
    localparam logic [63:0] DN14 = Q31_ONE - ((TQ14 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ15 = (((TQ14 + TAN_STEP_Q31) << 31) + DN14 / 2) / DN14;
    localparam logic [63:0] DN15 = Q31_ONE - ((TQ15 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ16 = (((TQ15 + TAN_STEP_Q31) << 31) + DN15 / 2) / DN15;
    localparam logic [63:0] DN16 = Q31_ONE - ((TQ16 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ17 = (((TQ16 + TAN_STEP_Q31) << 31) + DN16 / 2) / DN16;
    localparam logic [63:0] DN17 = Q31_ONE - ((TQ17 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ18 = (((TQ17 + TAN_STEP_Q31) << 31) + DN17 / 2) / DN17;
    localparam logic [63:0] DN18 = Q31_ONE - ((TQ18 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ19 = (((TQ18 + TAN_STEP_Q31) << 31) + DN18 / 2) / DN18;
    localparam logic [63:0] DN19 = Q31_ONE - ((TQ19 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ20 = (((TQ19 + TAN_STEP_Q31) << 31) + DN19 / 2) / DN19;
    localparam logic [63:0] DN20 = Q31_ONE - ((TQ20 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ21 = (((TQ20 + TAN_STEP_Q31) << 31) + DN20 / 2) / DN20;
    localparam logic [63:0] DN21 = Q31_ONE - ((TQ21 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ22 = (((TQ21 + TAN_STEP_Q31) << 31) + DN21 / 2) / DN21;
    localparam logic [63:0] DN22 = Q31_ONE - ((TQ22 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ23 = (((TQ22 + TAN_STEP_Q31) << 31) + DN22 / 2) / DN22;
    localparam logic [63:0] DN23 = Q31_ONE - ((TQ23 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ24 = (((TQ23 + TAN_STEP_Q31) << 31) + DN23 / 2) / DN23;
    localparam logic [63:0] DN24 = Q31_ONE - ((TQ24 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ25 = (((TQ24 + TAN_STEP_Q31) << 31) + DN24 / 2) / DN24;
    localparam logic [63:0] DN25 = Q31_ONE - ((TQ25 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ26 = (((TQ25 + TAN_STEP_Q31) << 31) + DN25 / 2) / DN25;
    localparam logic [63:0] DN26 = Q31_ONE - ((TQ26 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ27 = (((TQ26 + TAN_STEP_Q31) << 31) + DN26 / 2) / DN26;
    localparam logic [63:0] DN27 = Q31_ONE - ((TQ27 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ28 = (((TQ27 + TAN_STEP_Q31) << 31) + DN27 / 2) / DN27;
    localparam logic [63:0] DN28 = Q31_ONE - ((TQ28 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ29 = (((TQ28 + TAN_STEP_Q31) << 31) + DN28 / 2) / DN28;
    localparam logic [63:0] DN29 = Q31_ONE - ((TQ29 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ30 = (((TQ29 + TAN_STEP_Q31) << 31) + DN29 / 2) / DN29;
    localparam logic [63:0] DN30 = Q31_ONE - ((TQ30 * TAN_STEP_Q31 + Q31_HALF) >> 31);
    localparam logic [63:0] TQ31 = (((TQ30 + TAN_STEP_Q31) << 31) + DN30 / 2) / DN30;

    // Round a Q31 tangent half up to the angle fraction width.
    function automatic tan_t tan_round(input logic [63:0] t);
        logic [63:0] r;
        r = (t + (64'd1 << (30 - ANGLE_FRACTION_BITS))) >> (31 - ANGLE_FRACTION_BITS);
        return r[TAN_W-1:0];
    endfunction

    localparam tan_t TAN_TABLE [TAN_ENTRIES] = '{
        tan_round(TQ00), tan_round(TQ01), tan_round(TQ02), tan_round(TQ03),
        tan_round(TQ04), tan_round(TQ05), tan_round(TQ06), tan_round(TQ07),
        tan_round(TQ08), tan_round(TQ09), tan_round(TQ10), tan_round(TQ11),
        tan_round(TQ12), tan_round(TQ13), tan_round(TQ14), tan_round(TQ15),
        tan_round(TQ16), tan_round(TQ17), tan_round(TQ18), tan_round(TQ19),
        tan_round(TQ20), tan_round(TQ21), tan_round(TQ22), tan_round(TQ23),
        tan_round(TQ24), tan_round(TQ25), tan_round(TQ26), tan_round(TQ27),
        tan_round(TQ28), tan_round(TQ29), tan_round(TQ30), tan_round(TQ31)
    };

endpackage

// ----- sv/gmo_front.sv -----
// Front stage: display bytes, squared length, quadrant folding.
// Depends on gmo_pkg.
module gmo_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grad_valid,
    output logic                grad_ready,
    input  gmo_pkg::grad_t      horiz_gradient,
    input  gmo_pkg::grad_t      vert_gradient,
    output logic                down_valid,
    input  logic                down_ready,
    output gmo_pkg::gmo_item_t  down_item
);

    logic               valid_reg;
    gmo_pkg::gmo_item_t item_reg;
    gmo_pkg::gmo_item_t item_next;

    // Halve towards zero, add 128 and clamp to a byte.
    function automatic gmo_pkg::byte_t display_of(input gmo_pkg::grad_t g);
        logic signed [gmo_pkg::GRAD_W:0] ext;
        logic signed [gmo_pkg::GRAD_W:0] half;
        logic signed [gmo_pkg::GRAD_W:0] d;
        ext  = $signed({g[gmo_pkg::GRAD_W-1], g})
             + $signed({{gmo_pkg::GRAD_W{1'b0}}, g[gmo_pkg::GRAD_W-1]});
        half = ext >>> 1;
        d    = half + $signed((gmo_pkg::GRAD_W + 1)'(128));
        if (d < 0)
            return '0;
        else if (d > $signed((gmo_pkg::GRAD_W + 1)'(255)))
            return '1;
        else
            return d[gmo_pkg::BYTE_W-1:0];
    endfunction

    logic signed [gmo_pkg::GRAD_W-1:0] gx;
    logic signed [gmo_pkg::GRAD_W-1:0] gy;
    logic signed [gmo_pkg::SUM_W-1:0]  gx_sq;
    logic signed [gmo_pkg::SUM_W-1:0]  gy_sq;
    gmo_pkg::grad_t                    abs_x;
    gmo_pkg::grad_t                    abs_y;
    gmo_pkg::grad_t                    side_a;
    gmo_pkg::grad_t                    side_b;
    gmo_pkg::quad_t                    quad;

    assign gx    = $signed(horiz_gradient);
    assign gy    = $signed(vert_gradient);
    assign gx_sq = gmo_pkg::SUM_W'(gx) * gmo_pkg::SUM_W'(gx);
    assign gy_sq = gmo_pkg::SUM_W'(gy) * gmo_pkg::SUM_W'(gy);
    assign abs_x = gx[gmo_pkg::GRAD_W-1] ? gmo_pkg::grad_t'(-gx) : gmo_pkg::grad_t'(gx);
    assign abs_y = gy[gmo_pkg::GRAD_W-1] ? gmo_pkg::grad_t'(-gy) : gmo_pkg::grad_t'(gy);

    always_comb
    begin
        if (gx > 0 && gy >= 0)
        begin
            quad   = gmo_pkg::quad_t'(0);
            side_a = abs_x;
            side_b = abs_y;
        end
        else if (gx <= 0 && gy > 0)
        begin
            quad   = gmo_pkg::quad_t'(1);
            side_a = abs_y;
            side_b = abs_x;
        end
        else if (gx < 0 && gy <= 0)
        begin
            quad   = gmo_pkg::quad_t'(2);
            side_a = abs_x;
            side_b = abs_y;
        end
        else
        begin
            quad   = gmo_pkg::quad_t'(3);
            side_a = abs_y;
            side_b = abs_x;
        end
    end

    always_comb
    begin
        item_next.horiz_display = display_of(horiz_gradient);
        item_next.vert_display  = display_of(vert_gradient);
        item_next.sq_sum        = gmo_pkg::sum_t'(gx_sq) + gmo_pkg::sum_t'(gy_sq);
        item_next.root          = '0;
        item_next.shallow       = side_b < side_a;
        item_next.near_side     = (side_b < side_a) ? side_b : side_a;
        item_next.far_side      = (side_b < side_a) ? side_a : side_b;
        item_next.quadrant      = quad;
        item_next.zero_vec      = (gx == 0) && (gy == 0);
        item_next.step_idx      = '0;
    end

    assign grad_ready = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (grad_ready)
            valid_reg <= grad_valid;
    end

    always_ff @(posedge clk)
    begin
        if (grad_valid && grad_ready)
            item_reg <= item_next;
    end

endmodule

// ----- sv/gmo_cell.sv -----
// One cell of the chain: settles one root bit and, where given, one bit of
// the tangent table index. Depends on gmo_pkg.
module gmo_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  gmo_pkg::root_t      root_bit,
    input  gmo_pkg::idx_t       angle_bit,
    input  logic                up_valid,
    output logic                up_ready,
    input  gmo_pkg::gmo_item_t  up_item,
    output logic                down_valid,
    input  logic                down_ready,
    output gmo_pkg::gmo_item_t  down_item
);

    logic               valid_reg;
    gmo_pkg::gmo_item_t item_reg;
    gmo_pkg::gmo_item_t item_next;

    gmo_pkg::root_t trial_root;
    gmo_pkg::sq_t   trial_sq;
    gmo_pkg::idx_t  trial_idx;
    gmo_pkg::tan_t  trial_tan;
    gmo_pkg::prod_t far_prod;
    gmo_pkg::prod_t near_scaled;
    logic           root_take;
    logic           angle_take;

    assign trial_root  = up_item.root | root_bit;
    assign trial_sq    = gmo_pkg::sq_t'(trial_root) * gmo_pkg::sq_t'(trial_root);
    assign root_take   = gmo_pkg::sum_t'(trial_sq) <= up_item.sq_sum;

    // The thresholds rise with the index, so the comparison is true up to
    // some index and false beyond it: a binary search finds that edge.
    assign trial_idx   = up_item.step_idx | angle_bit;
    assign trial_tan   = gmo_pkg::TAN_TABLE[trial_idx];
    assign far_prod    = gmo_pkg::prod_t'(up_item.far_side) * gmo_pkg::prod_t'(trial_tan);
    assign near_scaled = gmo_pkg::prod_t'(up_item.near_side) << gmo_pkg::ANGLE_FRACTION_BITS;
    assign angle_take  = (angle_bit != '0)
                      && (up_item.shallow ? (near_scaled >= far_prod)
                                          : (near_scaled >  far_prod));

    always_comb
    begin
        item_next          = up_item;
        item_next.root     = root_take ? trial_root : up_item.root;
        item_next.step_idx = angle_take ? trial_idx : up_item.step_idx;
    end

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            item_reg <= item_next;
    end

endmodule

// ----- sv/gradient_magnitude_orientation.sv -----
// Top level of the gradient magnitude and orientation block.
// Depends on gmo_pkg, gmo_front and gmo_cell.
//
// This block takes the horizontal and vertical Sobel gradients of one pixel
// per item and returns four bytes: the two gradients halved towards zero,
// offset by 128 and clamped to a byte for display, the Euclidean length
// rounded down and clamped at 255, and the gradient angle in 256 equal steps
// of pi/128 around the full circle, with a zero vector giving angle 0. It
// accepts one item every clock cycle while the result side does not stall.
// The chain is one front stage that forms the display bytes, the squared
// length and the folded quadrant, eight identical cells of which each
// decides one bit of the square root and the first five also one bit of
// the binary search through the 32-entry tangent table (each cell holds two
// multipliers), and one output register. Every stage has its own valid flag
// and ready is passed back stage by stage, so empty slots in the chain are
// filled while a finished result waits to be taken, and a stall on the
// result side only holds back items once the chain is full.
// There is no configuration and no state between items.
module gradient_magnitude_orientation (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           grad_valid,
    output logic           grad_ready,
    input  gmo_pkg::grad_t horiz_gradient,
    input  gmo_pkg::grad_t vert_gradient,
    output logic           result_valid,
    input  logic           result_ready,
    output gmo_pkg::byte_t horiz_display,
    output gmo_pkg::byte_t vert_display,
    output gmo_pkg::byte_t magnitude,
    output gmo_pkg::byte_t orientation
);

    // Link 0 leaves the front stage, link i+1 leaves cell i.
    logic               link_valid [gmo_pkg::CELL_COUNT+1];
    logic               link_ready [gmo_pkg::CELL_COUNT+1];
    gmo_pkg::gmo_item_t link_item  [gmo_pkg::CELL_COUNT+1];

    gmo_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .grad_valid     (grad_valid),
        .grad_ready     (grad_ready),
        .horiz_gradient (horiz_gradient),
        .vert_gradient  (vert_gradient),
        .down_valid     (link_valid[0]),
        .down_ready     (link_ready[0]),
        .down_item      (link_item[0])
    );

    // Cell i tries root bit 128 >> i; the first cells also try table index
    // bits from the most significant down.
    for (genvar i = 0; i < gmo_pkg::CELL_COUNT; i++)
    begin : g_cell
        localparam gmo_pkg::root_t ROOT_BIT =
            gmo_pkg::root_t'(1 << (gmo_pkg::ROOT_W - 1 - i));
        localparam gmo_pkg::idx_t ANGLE_BIT = (i < gmo_pkg::ANGLE_CELLS)
            ? gmo_pkg::idx_t'(1 << (gmo_pkg::ANGLE_CELLS - 1 - i))
            : gmo_pkg::idx_t'(0);

        gmo_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .root_bit   (ROOT_BIT),
            .angle_bit  (ANGLE_BIT),
            .up_valid   (link_valid[i]),
            .up_ready   (link_ready[i]),
            .up_item    (link_item[i]),
            .down_valid (link_valid[i+1]),
            .down_ready (link_ready[i+1]),
            .down_item  (link_item[i+1])
        );
    end

    // Output register. The search leaves the last table index whose test
    // held; below the diagonal that index is the step itself, on and above it
    // the step counts back from the top of the quadrant.
    gmo_pkg::gmo_item_t last_item;
    gmo_pkg::step_t     step;
    gmo_pkg::byte_t     orient_next;

    logic           valid_reg;
    gmo_pkg::byte_t horiz_reg;
    gmo_pkg::byte_t vert_reg;
    gmo_pkg::byte_t mag_reg;
    gmo_pkg::byte_t orient_reg;

    assign last_item = link_item[gmo_pkg::CELL_COUNT];
    assign step      = last_item.shallow
                     ? gmo_pkg::step_t'(last_item.step_idx)
                     : gmo_pkg::step_t'(6'd63 - gmo_pkg::step_t'(last_item.step_idx));
    assign orient_next = last_item.zero_vec ? '0 : {last_item.quadrant, step};

    assign link_ready[gmo_pkg::CELL_COUNT] = !valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (link_ready[gmo_pkg::CELL_COUNT])
            valid_reg <= link_valid[gmo_pkg::CELL_COUNT];
    end

    always_ff @(posedge clk)
    begin
        if (link_valid[gmo_pkg::CELL_COUNT] && link_ready[gmo_pkg::CELL_COUNT])
        begin
            horiz_reg  <= last_item.horiz_display;
            vert_reg   <= last_item.vert_display;
            mag_reg    <= last_item.root;
            orient_reg <= orient_next;
        end
    end

    assign result_valid  = valid_reg;
    assign horiz_display = horiz_reg;
    assign vert_display  = vert_reg;
    assign magnitude     = mag_reg;
    assign orientation   = orient_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for gradient_magnitude_orientation.
// Depends on gmo_pkg for the port types and the angle fraction width, and on the RTL of the block.
module tb_top;

    localparam int QUARTER_STEPS = 64;
    localparam int TAN_COUNT     = 32;
    localparam int IDLE_PERCENT  = 30;
    localparam int TAIL_CYCLES   = 20;
    localparam logic [63:0] TAN_STEP_FIXED = 64'd52717765;

    typedef enum int {QUAD_EAST, QUAD_NORTH, QUAD_WEST, QUAD_SOUTH} quadrant_e;

    typedef struct {
        gmo_pkg::grad_t gx;
        gmo_pkg::grad_t gy;
        bit             drain_first;
    } gradient_pair_t;

    typedef struct {
        gmo_pkg::grad_t gx;
        gmo_pkg::grad_t gy;
        gmo_pkg::byte_t horiz_display;
        gmo_pkg::byte_t vert_display;
        gmo_pkg::byte_t magnitude;
        gmo_pkg::byte_t orientation;
    } pixel_bytes_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           grad_valid = 1'b0;
    logic           grad_ready;
    gmo_pkg::grad_t horiz_gradient = '0;
    gmo_pkg::grad_t vert_gradient = '0;
    logic           result_valid;
    logic           result_ready = 1'b0;
    gmo_pkg::byte_t horiz_display;
    gmo_pkg::byte_t vert_display;
    gmo_pkg::byte_t magnitude;
    gmo_pkg::byte_t orientation;

    gradient_pair_t pending_pairs[$];
    pixel_bytes_t   expected_bytes[$];
    logic [63:0]    tan_thresholds [TAN_COUNT];

    gradient_pair_t next_pair;
    pixel_bytes_t   want_bytes;
    int  pairs_offered = 0;
    int  pairs_accepted = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  saturated_lengths = 0;
    bit  steady_stretch = 1'b0;

    gradient_magnitude_orientation dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .grad_valid     (grad_valid),
        .grad_ready     (grad_ready),
        .horiz_gradient (horiz_gradient),
        .vert_gradient  (vert_gradient),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .horiz_display  (horiz_display),
        .vert_display   (vert_display),
        .magnitude      (magnitude),
        .orientation    (orientation)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A display byte is the gradient halved towards zero, lifted by 128 and
    // clamped to the byte range.
    function automatic gmo_pkg::byte_t clamp_display(int g);
        int d;
        d = g / 2 + 128;
        if (d < 0)
            d = 0;
        if (d > 255)
            d = 255;
        return gmo_pkg::byte_t'(d);
    endfunction

    // Works out the four result bytes of one gradient pair.
    function automatic pixel_bytes_t predict_pixel(gmo_pkg::grad_t gx_bits,
                                                   gmo_pkg::grad_t gy_bits);
        pixel_bytes_t res;
        int gx;
        int gy;
        int sum_sq;
        int root;
        int step;
        int cnt;
        quadrant_e quad;
        logic [63:0] near_len;
        logic [63:0] cross_len;
        gx = $signed(gx_bits);
        gy = $signed(gy_bits);
        res.gx = gx_bits;
        res.gy = gy_bits;
        res.horiz_display = clamp_display(gx);
        res.vert_display = clamp_display(gy);

        // Integer square root by counting up; anything from 255 on saturates.
        sum_sq = gx * gx + gy * gy;
        root = 0;
        while (root < 255 && (root + 1) * (root + 1) <= sum_sq)
            root++;
        res.magnitude = gmo_pkg::byte_t'(root);

        if (gx == 0 && gy == 0)
        begin
            res.orientation = '0;
            return res;
        end

        // Rotate by quarter turns so that the vector lies in the first
        // quadrant, with the near side strictly positive.
        if (gx > 0 && gy >= 0)
        begin
            quad = QUAD_EAST;
            near_len = 64'(gx);
            cross_len = 64'(gy);
        end
        else if (gx <= 0 && gy > 0)
        begin
            quad = QUAD_NORTH;
            near_len = 64'(gy);
            cross_len = 64'(-gx);
        end
        else if (gx < 0 && gy <= 0)
        begin
            quad = QUAD_WEST;
            near_len = 64'(-gx);
            cross_len = 64'(-gy);
        end
        else
        begin
            quad = QUAD_SOUTH;
            near_len = 64'(-gy);
            cross_len = 64'(gx);
        end

        // Below 45 degrees count the tangent thresholds passed from below;
        // from 45 degrees on count them from the far side of the quadrant.
        step = 0;
        if (cross_len < near_len)
        begin
            for (int k = 1; k < TAN_COUNT; k++)
                if ((cross_len << gmo_pkg::ANGLE_FRACTION_BITS)
                    >= near_len * tan_thresholds[k])
                    step++;
        end
        else
        begin
            cnt = 0;
            for (int k = 0; k < TAN_COUNT; k++)
                if ((near_len << gmo_pkg::ANGLE_FRACTION_BITS)
                    > cross_len * tan_thresholds[k])
                    cnt++;
            step = QUARTER_STEPS - cnt;
        end
        res.orientation = gmo_pkg::byte_t'(int'(quad) * QUARTER_STEPS + step);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_byte(string field, gmo_pkg::byte_t got, gmo_pkg::byte_t want,
                              pixel_bytes_t ref_bytes);
        if (got !== want)
            report_mismatch($sformatf("%s for gx=%0d gy=%0d: got %0d, expected %0d", field,
                                      $signed(ref_bytes.gx), $signed(ref_bytes.gy), got, want));
    endtask

    task automatic add_pair(int x, int y, bit drain_first);
        gradient_pair_t p;
        p.gx = gmo_pkg::grad_t'(x);
        p.gy = gmo_pkg::grad_t'(y);
        p.drain_first = drain_first;
        pending_pairs.push_back(p);
    endtask

    // Driver: offers the next pending item whenever the input slot is free,
    // idling at random outside the steady stretch. An item marked to drain
    // first is held back until every earlier result has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grad_valid <= 1'b0;
            horiz_gradient <= '0;
            vert_gradient <= '0;
        end
        else
        begin
            if (grad_valid && grad_ready)
            begin
                expected_bytes.push_back(predict_pixel(horiz_gradient, vert_gradient));
                pairs_accepted++;
            end
            if (!grad_valid || grad_ready)
            begin
                if (pending_pairs.size() > 0
                    && (steady_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)
                    && !(pending_pairs[0].drain_first && pairs_accepted != results_seen))
                begin
                    next_pair = pending_pairs.pop_front();
                    horiz_gradient <= next_pair.gx;
                    vert_gradient <= next_pair.gy;
                    grad_valid <= 1'b1;
                    pairs_offered++;
                end
                else
                begin
                    grad_valid <= 1'b0;
                end
            end
            // Roughly a hundred items in the middle of the run go through
            // with neither side idling.
            steady_stretch <= (pairs_offered >= 180 && pairs_offered < 280);
        end
    end

    // Monitor: takes results, stalling at random outside the steady stretch,
    // and compares each one with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("result arrived with no gradient pair waiting for it");
                end
                else
                begin
                    want_bytes = expected_bytes.pop_front();
                    if (want_bytes.magnitude == 8'd255)
                        saturated_lengths++;
                    check_byte("horiz_display", horiz_display, want_bytes.horiz_display,
                               want_bytes);
                    check_byte("vert_display", vert_display, want_bytes.vert_display, want_bytes);
                    check_byte("magnitude", magnitude, want_bytes.magnitude, want_bytes);
                    check_byte("orientation", orientation, want_bytes.orientation, want_bytes);
                end
            end
            result_ready <= steady_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        logic [63:0] t;
        logic [63:0] prod;
        logic [63:0] den;
        logic [63:0] num;
        int x;
        int y;
        int v;
        int kind;

        // Tangent thresholds tan(k*pi/128), built by the angle addition
        // recurrence in Q31 and rounded half up to the angle fraction width.
        t = '0;
        for (int k = 0; k < TAN_COUNT; k++)
        begin
            tan_thresholds[k] = (t + (64'd1 << (30 - gmo_pkg::ANGLE_FRACTION_BITS)))
                                >> (31 - gmo_pkg::ANGLE_FRACTION_BITS);
            prod = (t * TAN_STEP_FIXED + (64'd1 << 30)) >> 31;
            den = (64'd1 << 31) - prod;
            num = t + TAN_STEP_FIXED;
            t = ((num << 31) + den / 2) / den;
        end

        // Directed part: the zero vector, the four axes and diagonals, the
        // corners of the field range including -1024, both edges of display
        // saturation and the point where the length starts to saturate.
        add_pair(0, 0, 1'b0);
        add_pair(1, 0, 1'b0);
        add_pair(0, 1, 1'b0);
        add_pair(-1, 0, 1'b0);
        add_pair(0, -1, 1'b0);
        add_pair(5, 5, 1'b0);
        add_pair(-5, 5, 1'b0);
        add_pair(-5, -5, 1'b0);
        add_pair(5, -5, 1'b0);
        add_pair(1020, 1020, 1'b0);
        add_pair(-1020, -1020, 1'b0);
        add_pair(1023, -1024, 1'b0);
        add_pair(-1024, 1023, 1'b0);
        add_pair(-1024, -1024, 1'b0);
        add_pair(1023, 1023, 1'b0);
        add_pair(254, 255, 1'b0);
        add_pair(256, -256, 1'b0);
        add_pair(-257, -1, 1'b0);
        add_pair(-258, 1, 1'b0);
        add_pair(255, 0, 1'b0);
        add_pair(0, -254, 1'b0);
        add_pair(180, 180, 1'b0);
        add_pair(-181, 180, 1'b0);
        add_pair(1, 2, 1'b0);

        // Random part. The first random item, and one later on, wait until
        // the block has emptied out.
        for (int i = 0; i < 450; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                // Raw 11-bit patterns, so every input bit takes both values.
                x = $urandom_range(0, 2047);
                y = $urandom_range(0, 2047);
            end
            else if (kind <= 6)
            begin
                // Lengths mostly below saturation, so the root is exercised.
                x = $urandom_range(0, 400) - 200;
                y = $urandom_range(0, 400) - 200;
            end
            else if (kind == 7)
            begin
                // On an axis or a diagonal, where the quadrant fold and the
                // 45 degree split are decided.
                v = $urandom_range(1, 1023);
                if ($urandom_range(0, 1))
                    v = -v;
                case ($urandom_range(0, 3))
                    0: begin x = v; y = 0; end
                    1: begin x = 0; y = v; end
                    2: begin x = v; y = v; end
                    default: begin x = v; y = -v; end
                endcase
            end
            else if (kind == 8)
            begin
                // Around the edges of display saturation.
                x = $urandom_range(250, 262);
                y = $urandom_range(250, 262);
                if ($urandom_range(0, 1))
                    x = -x;
                if ($urandom_range(0, 1))
                    y = -y;
            end
            else
            begin
                // Tiny vectors, the zero vector among them.
                x = $urandom_range(0, 6) - 3;
                y = $urandom_range(0, 6) - 3;
            end
            add_pair(x, y, (i == 0 || i == 320));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() > 0 || grad_valid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_bytes.size()));
        $display("Sent %0d gradient pairs and checked %0d results (%0d with saturated length),",
                 pairs_accepted, results_seen, saturated_lengths);
        $display("covering axes, diagonals, range corners, zero vectors and display clamping.");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial
    begin
        #500000;
        $display("Run timed out with %0d results still expected", expected_bytes.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
